FILE: sv/bcdt_pkg.sv
// Shared types, constants and helper functions for the BCD timebase timer codec.
package bcdt_pkg;

  typedef struct packed {
    logic        command;
    logic [15:0] timer_word;
    logic [19:0] duration_ticks;
  } bcdt_in_t;

  typedef struct packed {
    logic [13:0] encoded_word;
    logic [20:0] decoded_ticks;
    logic        overflow;
  } bcdt_out_t;

  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // Time base codes as they sit in word bits 13:12
  localparam logic [1:0] BASE_10MS  = 2'd0;
  localparam logic [1:0] BASE_100MS = 2'd1;
  localparam logic [1:0] BASE_1S    = 2'd2;
  localparam logic [1:0] BASE_10S   = 2'd3;

  localparam logic [19:0] MAX_TICKS = 20'd999000;
  localparam logic [9:0]  SAT_DIGITS = 10'd999;

  // Reciprocals scaled by 2^RECIP_SHIFT, rounded up; exact for the ranges in use
  localparam int          RECIP_SHIFT = 30;
  localparam logic [26:0] RECIP_10    = 27'd107374183;
  localparam logic [26:0] RECIP_100   = 27'd10737419;
  localparam logic [26:0] RECIP_1000  = 27'd1073742;

  // Weighted sum of three nibbles, taken as they stand (no digit check)
  function automatic logic [10:0] digits_value(input logic [11:0] bcd);
    logic [10:0] hi;
    logic [10:0] mid;
    logic [10:0] lo;
    hi  = 11'(bcd[11:8]) * 11'd100;
    mid = 11'(bcd[7:4]) * 11'd10;
    lo  = 11'(bcd[3:0]);
    return 11'(hi + mid + lo);
  endfunction

  // Binary below 1000 to three BCD digits, by reciprocal multiplies
  function automatic logic [11:0] bcd3(input logic [9:0] q);
    logic [15:0] t;
    logic [3:0]  h;
    logic [6:0]  r;
    logic [14:0] u;
    logic [3:0]  d1;
    logic [3:0]  d0;
    t  = 16'(q) * 16'd41;
    h  = t[15:12];
    r  = 7'(q - 10'(10'(h) * 10'd100));
    u  = 15'(r) * 15'd205;
    d1 = u[14:11];
    d0 = 4'(r - 7'(7'(d1) * 7'd10));
    return {h, d1, d0};
  endfunction

endpackage

FILE: sv/bcd_timebase_timer_codec.sv
// Top level of the BCD timebase timer codec: three-stage conversion pipeline.
//
// Converts PLC timer words to 10 ms tick counts (command 0) and tick counts to
// timer words (command 1). One item enters per clock while in_ready is high;
// the pipeline is range select and digit sum, then one reciprocal or factor
// multiply, then BCD split into the output register. Each stage loads
// whenever the stage after it is empty or moving, so bubbles close up and
// out_ready low only stops in_ready once all three stages hold an item.
// Encoding saturates above 999000 ticks to 999 at the 10 s base and sets
// overflow; zero encodes as word 0.
module bcd_timebase_timer_codec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bcdt_pkg::bcdt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bcdt_pkg::bcdt_out_t out_data
);
  import bcdt_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_cmd_r;
  logic [1:0]  s1_base_r, s1_base_nxt;
  logic        s1_sat_r, s1_sat_nxt;
  logic [10:0] s1_dval_r;
  logic [19:0] s1_ticks_r;

  logic        s2_valid_r, s2_valid_nxt;
  logic        s2_cmd_r;
  logic [1:0]  s2_base_r;
  logic        s2_sat_r;
  logic [9:0]  s2_quot_r, s2_quot_nxt;
  logic [20:0] s2_dticks_r, s2_dticks_nxt;

  logic        out_valid_r, out_valid_nxt;
  bcdt_out_t   out_data_r, out_data_nxt;

  logic        rdy1, rdy2, rdy3;
  logic [26:0] recip;
  logic [46:0] prod;
  logic [10:0] factor;

  // Stage readiness: load when empty or when the downstream stage moves
  assign rdy3     = !out_valid_r || out_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;

  assign s1_valid_nxt  = rdy1 ? in_valid : s1_valid_r;
  assign s2_valid_nxt  = rdy2 ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = rdy3 ? s2_valid_r : out_valid_r;

  // Stage 1: pick the time base, by tick range for encoding or from word bits 13:12 for decoding
  always_comb begin
    s1_sat_nxt = 1'b0;
    if (in_data.duration_ticks > MAX_TICKS) begin
      s1_sat_nxt  = 1'b1;
      s1_base_nxt = BASE_10S;
    end else if (in_data.duration_ticks < 20'd1000) begin
      s1_base_nxt = BASE_10MS;
    end else if (in_data.duration_ticks < 20'd10000) begin
      s1_base_nxt = BASE_100MS;
    end else if (in_data.duration_ticks < 20'd100000) begin
      s1_base_nxt = BASE_1S;
    end else begin
      s1_base_nxt = BASE_10S;
    end
    if (in_data.command == CMD_DECODE) begin
      s1_base_nxt = in_data.timer_word[13:12];
      s1_sat_nxt  = 1'b0;
    end
  end

  // Stage 2: truncating divide by reciprocal, or scale by base factor
  always_comb begin
    case (s1_base_r)
      BASE_10MS:  begin recip = 27'd0;      factor = 11'd1;    end
      BASE_100MS: begin recip = RECIP_10;   factor = 11'd10;   end
      BASE_1S:    begin recip = RECIP_100;  factor = 11'd100;  end
      BASE_10S:   begin recip = RECIP_1000; factor = 11'd1000; end
      default:    begin recip = 27'd0;      factor = 11'd1;    end
    endcase
    prod          = 47'(s1_ticks_r) * 47'(recip);
    s2_dticks_nxt = 21'(s1_dval_r) * 21'(factor);
    if (s1_sat_r) begin
      s2_quot_nxt = SAT_DIGITS;
    end else if (s1_base_r == BASE_10MS) begin
      s2_quot_nxt = s1_ticks_r[9:0];
    end else begin
      s2_quot_nxt = prod[RECIP_SHIFT+9:RECIP_SHIFT];
    end
  end

  // Stage 3: split digits and zero the fields the command leaves unused
  always_comb begin
    out_data_nxt = '0;
    if (s2_cmd_r == CMD_ENCODE) begin
      out_data_nxt.encoded_word = {s2_base_r, bcd3(s2_quot_r)};
      out_data_nxt.overflow     = s2_sat_r;
    end else begin
      out_data_nxt.decoded_ticks = s2_dticks_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_cmd_r   <= in_data.command;
      s1_base_r  <= s1_base_nxt;
      s1_sat_r   <= s1_sat_nxt;
      s1_dval_r  <= digits_value(in_data.timer_word[11:0]);
      s1_ticks_r <= in_data.duration_ticks;
    end
    if (rdy2 && s1_valid_r) begin
      s2_cmd_r    <= s1_cmd_r;
      s2_base_r   <= s1_base_r;
      s2_sat_r    <= s1_sat_r;
      s2_quot_r   <= s2_quot_nxt;
      s2_dticks_r <= s2_dticks_nxt;
    end
    if (rdy3 && s2_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input only backs up once every stage is occupied
  a_full_before_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("in_ready low with a free pipeline stage");

  // Saturated encode must be 999 at the 10 s base, nothing decoded
  a_sat_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      (out_data.encoded_word == 14'h3999 && out_data.decoded_ticks == 21'd0))
    else $error("overflow without saturated word");

  // Encoded digits are always decimal
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.encoded_word[3:0] <= 4'd9 &&
                   out_data.encoded_word[7:4] <= 4'd9 &&
                   out_data.encoded_word[11:8] <= 4'd9))
    else $error("non-decimal digit in encoded word");

  // Only one of the two result fields can be nonzero
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.decoded_ticks != 21'd0) |->
      (out_data.encoded_word == 14'd0 && !out_data.overflow))
    else $error("decode and encode fields both set");

  // Stage 2 holds its item while stalled
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !rdy3) |=> (s2_valid_r && $stable(s2_quot_r) && $stable(s2_cmd_r)))
    else $error("stage 2 item changed under stall");

endmodule

FILE: sim/bcdt_checker.sv
`timescale 1ns / 100ps
// Checker for the BCD timebase timer codec: predicts each result and compares it.
module bcdt_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bcdt_pkg::bcdt_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bcdt_pkg::bcdt_out_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import bcdt_pkg::*;

  bcdt_out_t expected_q[$];

  function automatic bcdt_out_t predict_codec(input bcdt_in_t it);
    bcdt_out_t   r;
    int unsigned val;
    int unsigned scale;
    int unsigned n;
    int unsigned digits;
    logic [1:0]  base;
    r = '0;
    if (it.command == CMD_DECODE) begin
      // Nibbles weigh in as they stand, digit or not
      val = it.timer_word[11:8] * 100 + it.timer_word[7:4] * 10 + it.timer_word[3:0];
      case (it.timer_word[13:12])
        BASE_10MS:  scale = 1;
        BASE_100MS: scale = 10;
        BASE_1S:    scale = 100;
        default:    scale = 1000;
      endcase
      r.decoded_ticks = 21'(val * scale);
    end else begin
      n = it.duration_ticks;
      if (n > MAX_TICKS) begin
        base       = BASE_10S;
        digits     = 999;
        r.overflow = 1'b1;
      end else if (n < 1000) begin
        base   = BASE_10MS;
        digits = n;
      end else if (n < 10000) begin
        base   = BASE_100MS;
        digits = n / 10;
      end else if (n < 100000) begin
        base   = BASE_1S;
        digits = n / 100;
      end else begin
        base   = BASE_10S;
        digits = n / 1000;
      end
      r.encoded_word = {base, 4'(digits / 100), 4'((digits / 10) % 10), 4'(digits % 10)};
    end
    return r;
  endfunction

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bcdt_out_t want;
    if (!rst_n) begin
      expected_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_codec(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("item with nothing expected", out_data, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.encoded_word !== want.encoded_word)
            report("encoded_word", out_data.encoded_word, want.encoded_word);
          if (out_data.decoded_ticks !== want.decoded_ticks)
            report("decoded_ticks", out_data.decoded_ticks, want.decoded_ticks);
          if (out_data.overflow !== want.overflow)
            report("overflow", out_data.overflow, want.overflow);
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the BCD timebase timer codec: stimulus, pacing and verdict.
module tb_top;
  import bcdt_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 12;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  bcdt_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bcdt_out_t   out_data;
  int          fail_count;
  int          pending;
  int unsigned cycles    = 0;
  int          burst_left = 0;
  int          ready_pct  = 100;
  int          mode_left  = 0;

  bcd_timebase_timer_codec DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bcdt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Receiver: switch between four ready rates, each held for a random stretch
  always @(posedge clk) begin
    if (mode_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 70;
        2:       ready_pct = 30;
        default: ready_pct = 5;
      endcase
      mode_left = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    out_ready <= ($urandom_range(1, 100) <= ready_pct);
  end

  function automatic bcdt_in_t make_item(input logic cmd, input logic [15:0] word,
                                         input logic [19:0] ticks);
    bcdt_in_t it;
    it.command        = cmd;
    it.timer_word     = word;
    it.duration_ticks = ticks;
    return it;
  endfunction

  function automatic logic [19:0] rand_ticks();
    int bounds[9] = '{0, 999, 1000, 9999, 10000, 99999, 100000, 999000, 1000000};
    int v;
    case ($urandom_range(0, 5))
      0:       v = $urandom_range(0, 1048575);
      1:       v = $urandom_range(0, 999);
      2:       v = $urandom_range(1000, 9999);
      3:       v = $urandom_range(10000, 99999);
      4:       v = $urandom_range(100000, 999999);
      default: begin
        v = bounds[$urandom_range(0, 8)] + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v > 1048575) v = 1048575;
      end
    endcase
    return 20'(v);
  endfunction

  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    w = 16'($urandom);
    // Half the time forced to BCD digits, otherwise raw nibbles
    if ($urandom_range(0, 1) == 0) begin
      w[11:8] = 4'($urandom_range(0, 9));
      w[7:4]  = 4'($urandom_range(0, 9));
      w[3:0]  = 4'($urandom_range(0, 9));
    end
    return w;
  endfunction

  // Hold the item until accepted, then maybe drop valid for a gap
  task automatic send_item(input bcdt_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 24);
    end
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL bcd_timebase_timer_codec");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] words[10] = '{16'h0000, 16'hFFFF, 16'h3999, 16'h3FFF, 16'h0999,
                               16'h1123, 16'h2456, 16'hC000, 16'h0ABC, 16'h2F0F};
    int          ticks[13] = '{0, 1, 999, 1000, 9999, 10000, 99999, 100000,
                               999000, 999001, 999999, 1000000, 1048575};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (words[i]) send_item(make_item(CMD_DECODE, words[i], 20'($urandom)));
    foreach (ticks[i]) send_item(make_item(CMD_ENCODE, 16'($urandom), 20'(ticks[i])));

    repeat (RANDOM_ITEMS) begin
      send_item(make_item(1'($urandom_range(0, 1)), rand_word(), rand_ticks()));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS bcd_timebase_timer_codec");
    end else begin
      $display("FAIL bcd_timebase_timer_codec");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bcdt_pkg.sv
sv/bcd_timebase_timer_codec.sv
sim/bcdt_checker.sv
sim/tb_top.sv
